[hw/rtl/wtsf_pkg.sv]
// ----------------------------------------------------------------------------
// wtsf_pkg - wireless threat score filter package
// widths, fixed-point constants, codes and scale unit coefficients
// ----------------------------------------------------------------------------
package wtsf_pkg;

  localparam int FRAC_BITS = 8;

  // field widths
  localparam int RATE_W  = 24;
  localparam int ENT_W   = 16;
  localparam int RSSI_W  = 16;
  localparam int CHAN_W  = 8;
  localparam int OUT_SC_W = 12;
  localparam int SEV_W   = 2;
  localparam int KIND_W  = 3;
  localparam int CFG_A_W = 2;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USED_W = OUT_SC_W + SEV_W + KIND_W + CHAN_W;

  // internal widths
  localparam int Y_W     = FRAC_BITS + 4;   // scale unit result, up to 10.0
  localparam int SCORE_W = FRAC_BITS + 5;   // running sum, up to 18.0
  localparam int NUM_W   = FRAC_BITS + 7;   // smoothing numerator, up to 100.0
  localparam int K_W     = 25;
  localparam int P_W     = RATE_W + K_W;

  // reciprocal shifts and multipliers, exact over the clamped operand ranges
  localparam int SH_VEL = 30;
  localparam int SH_JAM = 24;
  localparam int SH_AVG = 26;
  localparam logic [K_W-1:0] K_VEL = K_W'(((64'd1 << SH_VEL) + 64'd49) / 64'd50);
  localparam logic [K_W-1:0] K_JAM = K_W'(64'd3 * (((64'd1 << SH_JAM) + 64'd19) / 64'd20));
  localparam logic [K_W-1:0] K_AVG = K_W'(((64'd1 << SH_AVG) + 64'd9) / 64'd10);
  localparam logic [K_W-1:0] K_DEAUTH = K_W'(3);
  localparam logic [K_W-1:0] K_SPOOF  = K_W'(1);

  // operand clamps: beyond them the capped result no longer changes
  localparam logic [RATE_W-1:0] VEL_CLAMP = RATE_W'(300 << FRAC_BITS);
  localparam logic [RATE_W-1:0] JAM_CLAMP = RATE_W'(20 << FRAC_BITS);

  // caps and thresholds at unit width
  localparam logic [Y_W-1:0] Y_TWO   = Y_W'(2 << FRAC_BITS);
  localparam logic [Y_W-1:0] Y_THREE = Y_W'(3 << FRAC_BITS);
  localparam logic [Y_W-1:0] Y_FIVE  = Y_W'(5 << FRAC_BITS);
  localparam logic [Y_W-1:0] Y_SIX   = Y_W'(6 << FRAC_BITS);
  localparam logic [Y_W-1:0] Y_SEVEN = Y_W'(7 << FRAC_BITS);
  localparam logic [Y_W-1:0] Y_TEN   = Y_W'(10 << FRAC_BITS);
  localparam logic [Y_W:0]   Y2_THREE = (Y_W+1)'(3 << FRAC_BITS);
  localparam logic [Y_W:0]   Y2_FIVE  = (Y_W+1)'(5 << FRAC_BITS);

  localparam logic [SCORE_W-1:0] SC_ONE   = SCORE_W'(1 << FRAC_BITS);
  localparam logic [SCORE_W-1:0] SC_SEVEN = SCORE_W'(7 << FRAC_BITS);
  localparam logic [SCORE_W-1:0] SC_TEN   = SCORE_W'(10 << FRAC_BITS);
  localparam logic [Y_W-1:0]     LAST_RST = Y_W'(1 << FRAC_BITS);

  localparam logic [RATE_W-1:0]  QUIET_ASSOC = RATE_W'(2 << FRAC_BITS);
  localparam logic signed [31:0] QUIET_RSSI  = -32'sd85 <<< FRAC_BITS;

  // attack kinds
  localparam logic [KIND_W-1:0] KIND_NORMAL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEAUTH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SPOOF  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VOLUME = 3'd3;
  localparam logic [KIND_W-1:0] KIND_JAM    = 3'd4;

  // severity levels
  localparam logic [SEV_W-1:0] SEV_NONE = 2'd0;
  localparam logic [SEV_W-1:0] SEV_LOW  = 2'd1;
  localparam logic [SEV_W-1:0] SEV_MED  = 2'd2;
  localparam logic [SEV_W-1:0] SEV_HIGH = 2'd3;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_DEAUTH_TH  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_ASSOC_TH   = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_RSSI_VAR_TH = 2'd2;

  // scale unit operations
  typedef enum logic [2:0] {
    OP_DEAUTH = 3'd0,
    OP_VEL    = 3'd1,
    OP_SPOOF  = 3'd2,
    OP_JAM    = 3'd3,
    OP_AVG    = 3'd4
  } wtsf_op_t;

endpackage

[hw/rtl/wtsf_scale_unit.sv]
// ----------------------------------------------------------------------------
// wtsf_scale_unit - shared multiply, shift and cap unit
// y = min((x * k) >> s, cap) with k, s and cap picked by the operation
// ----------------------------------------------------------------------------
module wtsf_scale_unit
  import wtsf_pkg::*;
(
  input  wtsf_op_t          op,
  input  logic [RATE_W-1:0] x,
  output logic [Y_W-1:0]    y
);

  logic [K_W-1:0] k;
  logic [P_W-1:0] prod;
  logic [P_W-1:0] shifted;
  logic [Y_W-1:0] cap;

  always_comb begin
    case (op)
      OP_DEAUTH: begin k = K_DEAUTH; cap = Y_FIVE;  end
      OP_VEL:    begin k = K_VEL;    cap = Y_SIX;   end
      OP_SPOOF:  begin k = K_SPOOF;  cap = Y_THREE; end
      OP_JAM:    begin k = K_JAM;    cap = Y_THREE; end
      OP_AVG:    begin k = K_AVG;    cap = Y_TEN;   end
      default:   begin k = '0;       cap = '0;      end
    endcase
  end

  assign prod = P_W'(x) * P_W'(k);

  // constant shifts only, one per operation
  always_comb begin
    case (op)
      OP_DEAUTH: shifted = prod >> 1;
      OP_VEL:    shifted = prod >> SH_VEL;
      OP_SPOOF:  shifted = prod >> 1;
      OP_JAM:    shifted = prod >> SH_JAM;
      OP_AVG:    shifted = prod >> SH_AVG;
      default:   shifted = '0;
    endcase
  end

  assign y = (shifted < P_W'(cap)) ? shifted[Y_W-1:0] : cap;

endmodule

[hw/rtl/wireless_threat_score_filter_top.sv]
// ----------------------------------------------------------------------------
// wireless_threat_score_filter_top - wireless threat score filter
// scores one feature vector, smooths it against the previous score
// ----------------------------------------------------------------------------
// usage
//   in_*   : one feature vector per word; accepted when in_tvalid && in_tready
//   out_*  : one result word per input word, held in an output register
//   cfg_*  : threshold writes, index 0 deauth, 1 assoc, 2 rssi variance;
//            index 3 is ignored; write only while the block is idle
// timing
//   a sequencer walks one item through deauth, velocity, spoof, jamming,
//   final and smoothing steps; every penalty and the divide by ten go
//   through the one shared multiply/shift/cap unit, one step per cycle
//   out_tvalid rises once the smoothing step has loaded the output register;
//   a new word is accepted only after the sequencer has returned to idle
// reset
//   thresholds clear to 0, the previous score returns to 1.0, no result pending
// backpressure
//   a waiting result does not block the next accept; the smoothing step
//   holds until the output register is free
// ----------------------------------------------------------------------------
module wireless_threat_score_filter_top
  import wtsf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: disassoc_freq[23:0], assoc_freq[47:24], addr_entropy[63:48],
  //           rssi_spread[87:64], rssi_mean[103:88], busy_chan[111:104]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // out_tdata: filt_score[11:0], severity[13:12], attack_kind[16:14],
  //            threat_chan[24:17], zeros[31:25]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_A_W-1:0]     cfg_addr,
  input  logic [RATE_W-1:0]      cfg_wdata
);

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DEAUTH = 7'b0000010,
    ST_VEL    = 7'b0000100,
    ST_SPOOF  = 7'b0001000,
    ST_JAM    = 7'b0010000,
    ST_FINAL  = 7'b0100000,
    ST_SMOOTH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // thresholds
  logic [RATE_W-1:0] deauth_th_r, assoc_th_r, rssi_var_th_r;

  // latched item
  logic [RATE_W-1:0]        disassoc_r, assoc_r, rvar_r;
  logic [ENT_W-1:0]         entropy_r;
  logic signed [RSSI_W-1:0] rssi_r;
  logic [CHAN_W-1:0]        chan_r;

  // working registers
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [RATE_W-1:0]  opnd_r, opnd_nxt;
  logic               hit_r, hit_nxt;
  logic [Y_W-1:0]     vel_r, vel_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [Y_W-1:0]     last_r, last_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_SC_W-1:0] out_score_r;
  logic [SEV_W-1:0]    out_sev_r, sev_nxt;
  logic [KIND_W-1:0]   out_kind_r;
  logic [CHAN_W-1:0]   out_chan_r;

  // shared unit
  wtsf_op_t          unit_op;
  logic [RATE_W-1:0] unit_x;
  logic [Y_W-1:0]    unit_y;

  logic in_acc;
  logic out_free;
  logic load_out;

  // step helpers
  logic [RATE_W-1:0]  diff;
  logic [SCORE_W-1:0] jam_sum;
  logic               quiet;
  logic [SCORE_W-1:0] sc_final;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign load_out  = (state_r == ST_SMOOTH) && out_free;

  // operand routing into the shared unit
  always_comb begin
    case (state_r)
      ST_DEAUTH: begin unit_op = OP_DEAUTH; unit_x = disassoc_r;        end
      ST_VEL:    begin unit_op = OP_VEL;    unit_x = opnd_r;            end
      ST_SPOOF:  begin unit_op = OP_SPOOF;  unit_x = RATE_W'(entropy_r); end
      ST_JAM:    begin unit_op = OP_JAM;    unit_x = opnd_r;            end
      default:   begin unit_op = OP_AVG;    unit_x = RATE_W'(num_r);    end
    endcase
  end

  wtsf_scale_unit u_unit (
    .op (unit_op),
    .x  (unit_x),
    .y  (unit_y)
  );

  assign jam_sum  = score_r + SCORE_W'(unit_y);
  assign quiet    = (assoc_r < QUIET_ASSOC) &&
                    ($signed({{(32-RSSI_W){rssi_r[RSSI_W-1]}}, rssi_r}) <= QUIET_RSSI);
  assign sc_final = quiet ? SC_ONE : ((score_r < SC_TEN) ? score_r : SC_TEN);

  // severity from the smoothed score
  always_comb begin
    if (unit_y >= Y_SEVEN) begin
      sev_nxt = SEV_HIGH;
    end else if (unit_y >= Y_FIVE) begin
      sev_nxt = SEV_MED;
    end else if ({unit_y, 1'b0} >= Y2_FIVE) begin
      sev_nxt = SEV_LOW;
    end else begin
      sev_nxt = SEV_NONE;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    score_nxt = score_r;
    kind_nxt  = kind_r;
    opnd_nxt  = opnd_r;
    hit_nxt   = hit_r;
    vel_nxt   = vel_r;
    num_nxt   = num_r;
    last_nxt  = last_r;
    diff      = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          score_nxt = SC_ONE;
          kind_nxt  = KIND_NORMAL;
          state_nxt = ST_DEAUTH;
        end
      end
      ST_DEAUTH: begin
        if (disassoc_r > deauth_th_r) begin
          score_nxt = score_r + SCORE_W'(unit_y);
          if (unit_y > Y_THREE) begin
            kind_nxt = KIND_DEAUTH;
          end
        end
        // prepare the clamped association excess
        hit_nxt   = assoc_r > assoc_th_r;
        diff      = assoc_r - assoc_th_r;
        opnd_nxt  = (diff < VEL_CLAMP) ? diff : VEL_CLAMP;
        state_nxt = ST_VEL;
      end
      ST_VEL: begin
        vel_nxt   = unit_y;
        state_nxt = ST_SPOOF;
      end
      ST_SPOOF: begin
        if (hit_r) begin
          score_nxt = score_r + SCORE_W'(vel_r) + SCORE_W'(unit_y);
          if ({unit_y, 1'b0} > Y2_THREE) begin
            kind_nxt = KIND_SPOOF;
          end else if (vel_r > Y_TWO && kind_r == KIND_NORMAL) begin
            kind_nxt = KIND_VOLUME;
          end
        end
        // prepare the clamped variance excess
        hit_nxt   = rvar_r > rssi_var_th_r;
        diff      = rvar_r - rssi_var_th_r;
        opnd_nxt  = (diff < JAM_CLAMP) ? diff : JAM_CLAMP;
        state_nxt = ST_JAM;
      end
      ST_JAM: begin
        if (hit_r) begin
          score_nxt = jam_sum;
          if ({unit_y, 1'b0} > Y2_THREE && jam_sum < SC_SEVEN &&
              kind_r == KIND_NORMAL) begin
            kind_nxt = KIND_JAM;
          end
        end
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        // cap, quiet-air override, then 3*raw + 7*last + 5
        if (quiet) begin
          kind_nxt = KIND_NORMAL;
        end
        num_nxt = (NUM_W'(sc_final) << 1) + NUM_W'(sc_final) +
                  (NUM_W'(last_r) << 3) - NUM_W'(last_r) + NUM_W'(5);
        state_nxt = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        if (out_free) begin
          last_nxt      = unit_y;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state and thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      last_r        <= LAST_RST;
      deauth_th_r   <= '0;
      assoc_th_r    <= '0;
      rssi_var_th_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_DEAUTH_TH:   deauth_th_r   <= cfg_wdata;
          REG_ASSOC_TH:    assoc_th_r    <= cfg_wdata;
          REG_RSSI_VAR_TH: rssi_var_th_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      disassoc_r <= in_tdata[23:0];
      assoc_r    <= in_tdata[47:24];
      entropy_r  <= in_tdata[63:48];
      rvar_r     <= in_tdata[87:64];
      rssi_r     <= $signed(in_tdata[103:88]);
      chan_r     <= in_tdata[111:104];
    end
    score_r <= score_nxt;
    kind_r  <= kind_nxt;
    opnd_r  <= opnd_nxt;
    hit_r   <= hit_nxt;
    vel_r   <= vel_nxt;
    num_r   <= num_nxt;
    if (load_out) begin
      out_score_r <= unit_y[OUT_SC_W-1:0];
      out_sev_r   <= sev_nxt;
      out_kind_r  <= kind_r;
      out_chan_r  <= chan_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-OUT_USED_W)'(0), out_chan_r, out_kind_r,
                       out_sev_r, out_score_r};

endmodule

[hw/rtl/wtsf_checker.sv]
// ----------------------------------------------------------------------------
// wtsf_checker - port checks for the threat score filter
// watches the top level's handshakes and result words
// ----------------------------------------------------------------------------
module wtsf_checker
  import wtsf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // the block is busy right after taking a word
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accept");

  // reset leaves an idle block with nothing pending
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

  // kind in range and padding clear on every result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:14] <= KIND_JAM &&
                   out_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
    else $error("bad result word");

endmodule

bind wireless_threat_score_filter_top wtsf_checker u_wtsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[bench/wireless_threat_score_filter_top_test.sv]
// ----------------------------------------------------------------------------
// wireless_threat_score_filter_top_test - self-checking bench for the filter
// feeds feature vectors through the stream port, scores each accepted word
// with an independent fixed-point predictor and compares every result word
// field by field; thresholds are changed between phases while the block idles
// ----------------------------------------------------------------------------
module wireless_threat_score_filter_top_test;
  import wtsf_pkg::*;

  localparam int CLK_HALF          = 6;
  localparam int RESET_CYCLES      = 9;
  localparam int PHASES            = 8;
  localparam int WINDOWS_PER_PHASE = 219;
  localparam int HOLD_CYCLES       = 300;
  localparam int DRAIN_CYCLES      = 20;
  localparam int WATCHDOG          = 6_000_000;
  localparam int MAX_PRINTED       = 100;
  localparam int RATE_MAX          = 24'hFFFFFF;

  // index 3 decodes to nothing
  localparam logic [CFG_A_W-1:0] REG_UNUSED = 2'd3;

  localparam longint ONE      = longint'(1) << FRAC_BITS;
  localparam int     QUIET_DB = -85 * (1 << FRAC_BITS);

  // one feature vector, first field in the lowest bits, same layout as in_tdata
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [RSSI_W-1:0] rssi_mean;
    logic [RATE_W-1:0] rssi_var;
    logic [ENT_W-1:0]  entropy;
    logic [RATE_W-1:0] assoc;
    logic [RATE_W-1:0] disassoc;
  } feature_t;

  // one verdict, same layout as the used bits of out_tdata
  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [KIND_W-1:0]   kind;
    logic [SEV_W-1:0]    sev;
    logic [OUT_SC_W-1:0] score;
  } verdict_t;

  // traffic shape of a run of random windows
  typedef enum int {
    MIX_ANY    = 0,
    MIX_QUIET  = 1,
    MIX_ATTACK = 2
  } traffic_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // in_tdata: disassoc_freq, assoc_freq, addr_entropy, rssi_spread,
  //           rssi_mean, busy_chan
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata: filt_score, severity, attack_kind, threat_chan, zeros
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_A_W-1:0]    cfg_addr   = '0;
  logic [RATE_W-1:0]     cfg_wdata  = '0;

  // predictor copy of the thresholds and the smoothing memory
  longint th_deauth   = 0;
  longint th_assoc    = 0;
  longint th_rssi_var = 0;
  longint prev_score  = ONE;

  feature_t windows_to_send[$];
  verdict_t predicted_verdicts[$];
  feature_t on_wire;
  verdict_t got_verdict;
  verdict_t want_verdict;
  logic     offer_free;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_tag      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int mismatches    = 0;

  wireless_threat_score_filter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic longint clip_to(longint v, longint lim);
    return (v < lim) ? v : lim;
  endfunction

  // score one window against the current thresholds and advance the smoothing
  function automatic verdict_t score_window(feature_t f);
    longint d, a, e, r, rs, raw, pen, vel, spoof, jam, sm;
    logic [KIND_W-1:0] kind;
    verdict_t v;
    d = longint'(f.disassoc);
    a = longint'(f.assoc);
    e = longint'(f.entropy);
    r = longint'(f.rssi_var);
    rs = longint'($signed(f.rssi_mean));
    raw = ONE;
    kind = KIND_NORMAL;
    // deauth flood: penalty 1.5 x rate, capped at 5.0
    if (d > th_deauth) begin
      pen = clip_to(d * 3 / 2, 5 * ONE);
      raw += pen;
      if (pen > 3 * ONE) kind = KIND_DEAUTH;
    end
    // association burst: velocity over the threshold plus address spread
    if (a > th_assoc) begin
      vel = clip_to((a - th_assoc) / 50, 6 * ONE);
      spoof = clip_to(e / 2, 3 * ONE);
      raw += vel + spoof;
      if (2 * spoof > 3 * ONE) kind = KIND_SPOOF;
      else if (vel > 2 * ONE && kind == KIND_NORMAL) kind = KIND_VOLUME;
    end
    // jamming only claims the kind while the running sum stays below 7.0
    if (r > th_rssi_var) begin
      jam = clip_to((r - th_rssi_var) * 3 / 20, 3 * ONE);
      raw += jam;
      if (2 * jam > 3 * ONE && raw < 7 * ONE && kind == KIND_NORMAL) kind = KIND_JAM;
    end
    raw = clip_to(raw, 10 * ONE);
    // quiet air wins over everything
    if (a < 2 * ONE && rs <= QUIET_DB) begin
      raw = ONE;
      kind = KIND_NORMAL;
    end
    sm = (3 * raw + 7 * prev_score + 5) / 10;
    prev_score = sm;
    v.score = sm[OUT_SC_W-1:0];
    if (sm >= 7 * ONE) v.sev = SEV_HIGH;
    else if (sm >= 5 * ONE) v.sev = SEV_MED;
    else if (2 * sm >= 5 * ONE) v.sev = SEV_LOW;
    else v.sev = SEV_NONE;
    v.kind = kind;
    v.chan = f.chan;
    return v;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // sender: offers the next pending window, holds it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offer_free = !in_tvalid || in_tready;
      if (in_tvalid && in_tready) predicted_verdicts.push_back(score_window(on_wire));
      if (offer_free) begin
        if (windows_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = windows_to_send.pop_front();
          in_tdata <= on_wire;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker: every accepted word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_verdict = verdict_t'(out_tdata[OUT_USED_W-1:0]);
      if (predicted_verdicts.size() == 0) begin
        flag_mismatch($sformatf("result word %h with nothing expected", out_tdata));
      end else begin
        want_verdict = predicted_verdicts.pop_front();
        if (got_verdict.score != want_verdict.score)
          flag_mismatch($sformatf("filt_score %0d, expected %0d",
                                  got_verdict.score, want_verdict.score));
        if (got_verdict.sev != want_verdict.sev)
          flag_mismatch($sformatf("severity %0d, expected %0d",
                                  got_verdict.sev, want_verdict.sev));
        if (got_verdict.kind != want_verdict.kind)
          flag_mismatch($sformatf("attack_kind %0d, expected %0d",
                                  got_verdict.kind, want_verdict.kind));
        if (got_verdict.chan != want_verdict.chan)
          flag_mismatch($sformatf("threat_chan %0d, expected %0d",
                                  got_verdict.chan, want_verdict.chan));
      end
    end
  end

  task automatic push_window(int d, int a, int e, int r, int rssi, int chan);
    feature_t f;
    f.disassoc  = d[RATE_W-1:0];
    f.assoc     = a[RATE_W-1:0];
    f.entropy   = e[ENT_W-1:0];
    f.rssi_var  = r[RATE_W-1:0];
    f.rssi_mean = rssi[RSSI_W-1:0];
    f.chan      = chan[CHAN_W-1:0];
    windows_to_send.push_back(f);
  endtask

  // only the low register bits reach the block and the predictor
  task automatic write_threshold(logic [CFG_A_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[RATE_W-1:0];
    case (idx)
      REG_DEAUTH_TH:   th_deauth = longint'(value[RATE_W-1:0]);
      REG_ASSOC_TH:    th_assoc = longint'(value[RATE_W-1:0]);
      REG_RSSI_VAR_TH: th_rssi_var = longint'(value[RATE_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // idle means nothing queued, nothing offered and nothing outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (windows_to_send.size() != 0 || in_tvalid || predicted_verdicts.size() != 0);
  endtask

  // rate near its threshold, near zero or anywhere; strictly above when asked, unless clipped at RATE_MAX
  function automatic logic [RATE_W-1:0] pick_rate(longint th, int unsigned span,
                                                  bit above);
    longint v;
    if (above) begin
      v = th + $urandom_range(span, 1);
    end else begin
      case ($urandom_range(3))
        0:       v = $urandom & RATE_MAX;
        1:       v = $urandom_range(span);
        2:       v = th + $urandom_range(span);
        default: v = th - $urandom_range(16);
      endcase
    end
    if (v < 0) v = 0;
    if (v > RATE_MAX) v = RATE_MAX;
    return v[RATE_W-1:0];
  endfunction

  function automatic logic [RSSI_W-1:0] pick_rssi();
    int rs;
    if ($urandom_range(1) == 0) rs = $urandom_range(16'hFFFF);
    else rs = QUIET_DB + $urandom_range(128) - 64;
    return rs[RSSI_W-1:0];
  endfunction

  // runs of quiet air, attacks or anything, so the smoothing swings fully
  task automatic queue_random_windows(int count);
    feature_t f;
    traffic_t mix;
    int run;
    int rs;
    int i;
    run = 0;
    mix = MIX_ANY;
    for (i = 0; i < count; i++) begin
      if (run == 0) begin
        mix = traffic_t'($urandom_range(2));
        run = $urandom_range(12, 1);
      end
      run--;
      f.disassoc = pick_rate(th_deauth, 1200, mix == MIX_ATTACK);
      f.rssi_var = pick_rate(th_rssi_var, 6000, mix == MIX_ATTACK);
      f.chan = CHAN_W'($urandom_range(255));
      if ($urandom_range(1) == 0) f.entropy = ENT_W'($urandom_range(2000));
      else f.entropy = ENT_W'($urandom_range(16'hFFFF));
      if (mix == MIX_QUIET) begin
        f.assoc = RATE_W'($urandom_range(600));
        rs = QUIET_DB - int'($urandom_range(11008));
        f.rssi_mean = rs[RSSI_W-1:0];
      end else begin
        f.assoc = pick_rate(th_assoc, 100000, mix == MIX_ATTACK);
        f.rssi_mean = pick_rssi();
      end
      windows_to_send.push_back(f);
    end
  endtask

  // stimulus and phase control
  initial begin
    int p;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed windows, thresholds still at their reset value of zero
    push_window(0, 0, 0, 0, 0, 0);
    // every field at its top: penalties sum past ten and get capped
    repeat (4) push_window(RATE_MAX, RATE_MAX, 16'hFFFF, RATE_MAX, 16'h7FFF, 8'hFF);
    // quiet air with the most negative rssi
    push_window(0, 0, 0, 0, -32768, 8'h55);
    // quiet air at exactly -85 dBm overrides every penalty
    push_window(RATE_MAX, 511, 16'hFFFF, RATE_MAX, QUIET_DB, 1);
    // association rate at 2.0 breaks the quiet test
    push_window(RATE_MAX, 512, 16'hFFFF, RATE_MAX, QUIET_DB, 2);
    // rssi one step above -85 dBm
    push_window(RATE_MAX, 0, 16'hFFFF, RATE_MAX, QUIET_DB + 1, 3);
    // deauth penalty at exactly 3.0, then just past it
    push_window(512, 0, 0, 0, 0, 4);
    push_window(513, 0, 0, 0, 0, 5);
    // spoof at exactly 1.5, then just past it
    push_window(0, 1, 769, 0, 0, 6);
    push_window(0, 1, 770, 0, 0, 7);
    // velocity at exactly 2.0, then just past it
    push_window(0, 25600, 0, 0, 0, 8);
    push_window(0, 25651, 0, 0, 0, 9);
    // jamming at exactly 1.5, then just past it
    push_window(0, 0, 0, 2560, 0, 10);
    push_window(0, 0, 0, 2567, 0, 11);
    // spoofing takes priority over a deauth flood
    push_window(1000, 1, 2000, 0, 0, 12);
    // deauth flood keeps its kind against high volume
    push_window(1000, 30000, 0, 0, 0, 13);
    // jamming loses its kind once the running sum reaches 7.0
    push_window(512, 25600, 768, 6000, 0, 14);
    // all rates at the top with quiet-level rssi but busy association
    push_window(RATE_MAX, RATE_MAX, 0, RATE_MAX, -32768, 15);
    repeat (3) push_window(0, 0, 0, 0, 0, 8'hAA);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_threshold(REG_DEAUTH_TH, 0);
          write_threshold(REG_ASSOC_TH, 0);
          write_threshold(REG_RSSI_VAR_TH, 0);
        end
        1: begin
          write_threshold(REG_DEAUTH_TH, 768);
          write_threshold(REG_ASSOC_TH, 2048);
          write_threshold(REG_RSSI_VAR_TH, 1024);
        end
        2: begin
          write_threshold(REG_DEAUTH_TH, RATE_MAX);
          write_threshold(REG_ASSOC_TH, RATE_MAX);
          write_threshold(REG_RSSI_VAR_TH, RATE_MAX);
          // write to the empty index must change nothing
          write_threshold(REG_UNUSED, $urandom);
        end
        3, 6: begin
          write_threshold(REG_DEAUTH_TH, $urandom_range(1500));
          write_threshold(REG_ASSOC_TH, $urandom_range(60000));
          write_threshold(REG_RSSI_VAR_TH, $urandom_range(8000));
        end
        4: begin
          write_threshold(REG_DEAUTH_TH, $urandom);
          write_threshold(REG_ASSOC_TH, $urandom_range(4096));
          write_threshold(REG_RSSI_VAR_TH, $urandom);
        end
        5: begin
          write_threshold(REG_DEAUTH_TH, 256);
          write_threshold(REG_ASSOC_TH, 0);
          write_threshold(REG_RSSI_VAR_TH, 4096);
          write_threshold(REG_UNUSED, 0);
        end
        default: begin
          write_threshold(REG_DEAUTH_TH, 0);
          write_threshold(REG_ASSOC_TH, RATE_MAX);
          write_threshold(REG_RSSI_VAR_TH, 0);
        end
      endcase

      // idling pattern: none, sender, receiver, both
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 82; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase

      // long receiver hold while the sender keeps pushing: input must stall
      if (p == 4) hold_tag++;
      queue_random_windows(WINDOWS_PER_PHASE / 2);
      // sender pauses until every result is back
      if (p == 1) wait_idle();
      queue_random_windows(WINDOWS_PER_PHASE - WINDOWS_PER_PHASE / 2);
      wait_idle();
    end

    // catch any stray result word after the last one expected
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("wireless_threat_score_filter_top_test OK");
    end else begin
      $display("wireless_threat_score_filter_top_test NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #WATCHDOG;
    $display("wireless_threat_score_filter_top_test NOT OK");
    $finish;
  end

endmodule
